// ===== rtl/maf_pkg.sv =====
package maf_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd16;

endpackage

// ===== rtl/maf_store.sv =====
module maf_store #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/maf_div.sv =====
module maf_div #(
	parameter int DVD_W = 22,
	parameter int DSR_W = 7,
	parameter int QUO_W = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DVD_W-1:0] dividend,
	input  logic        [DSR_W-1:0] divisor,
	output logic                    done,
	output logic signed [QUO_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DSR_W-1:0]  dsr_q;
	logic              neg_q;

	logic [DVD_W-1:0] dvd_u;
	logic [DVD_W-1:0] mag;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             take;
	logic [QUO_W-1:0] quo_low;

	// restoring division on the magnitude, one quotient bit per cycle
	assign dvd_u   = dividend;
	assign mag     = dvd_u[DVD_W-1] ? (~dvd_u + DVD_W'(1)) : dvd_u;
	assign trial   = {rem_q, quo_q[DVD_W-1]};
	assign take    = (trial >= {1'b0, dsr_q});
	assign diff    = trial - {1'b0, dsr_q};
	assign quo_low = quo_q[QUO_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(DVD_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			dsr_q <= divisor;
			neg_q <= dvd_u[DVD_W-1];
		end else if (busy_q) begin
			rem_q <= take ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_low + QUO_W'(1)) : quo_low;

endmodule

// ===== rtl/moving_average_filter_top.sv =====
// channel   | handshake           | payload
// ----------+---------------------+---------------------------
// input     | in_valid, in_ready  | sample
// output    | out_valid, out_ready| mean, count
// config    | cfg_we              | window_size
//
// one beat passes a store read (S_IDLE), a read-modify-write of the store and running
// sum (S_RMW), the bit-serial divider (S_DIV) and a move to the output register (S_OUT)
// a new input beat is taken once the divider result has moved to the output register,
// so the next beat overlaps a result still waiting on out_ready
// out_ready low holds the result and stalls the block only when a second result is done
// arst_n clears the fill count, index, sum and the output valid; window_size resets to 16
module moving_average_filter_top #(
	parameter int WINDOW_MAX  = maf_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = $clog2(WINDOW_MAX + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [maf_pkg::CFG_W-1:0]     window_size,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] mean,
	output logic        [CNT_W-1:0]       count
);

	import maf_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam int SUM_W = SAMPLE_BITS + IDX_W;
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RMW  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         ws_q;
	logic [IDX_W-1:0]         idx_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                     out_valid_q;
	logic signed [SAMPLE_BITS-1:0] mean_q;
	logic [CNT_W-1:0]         count_q;

	logic [CNT_W-1:0]              win_eff;
	logic                          in_acc;
	logic signed [SAMPLE_BITS-1:0] rd_data;
	logic signed [SAMPLE_BITS-1:0] old_smp;
	logic signed [SUM_W-1:0]       sum_n;
	logic [IDX_W-1:0]              idx_n;
	logic [CNT_W-1:0]              cnt_n;
	logic                          div_start;
	logic                          div_done;
	logic signed [SAMPLE_BITS-1:0] div_quo;
	logic                          out_free;

	// window of zero acts as one, oversized window clamps to the store depth
	always_comb begin
		if (ws_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (CMP_W'(ws_q) > CMP_W'(WINDOW_MAX)) begin
			win_eff = CNT_W'(WINDOW_MAX);
		end else begin
			win_eff = CNT_W'(ws_q);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign div_start = (state_q == S_RMW);

	// oldest sample drops out only once the window is full
	assign old_smp = (cnt_q == win_eff) ? rd_data : '0;
	assign sum_n   = sum_q - SUM_W'(old_smp) + SUM_W'(sample_q);
	assign idx_n   = ((CNT_W'(idx_q) + CNT_W'(1)) == win_eff) ? '0 : idx_q + IDX_W'(1);
	assign cnt_n   = (cnt_q < win_eff) ? cnt_q + CNT_W'(1) : cnt_q;

	maf_store #(
		.DEPTH  (WINDOW_MAX),
		.DATA_W (SAMPLE_BITS)
	) u_store (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (idx_q),
		.rd_data (rd_data),
		.wr_en   (state_q == S_RMW),
		.wr_addr (idx_q),
		.wr_data (sample_q)
	);

	maf_div #(
		.DVD_W (SUM_W),
		.DSR_W (CNT_W),
		.QUO_W (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_n),
		.divisor  (cnt_n),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_RMW;
					end
				end
				S_RMW: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q  <= WINDOW_RESET;
			idx_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cfg_we) begin
			ws_q  <= window_size;
			idx_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
		end else if (state_q == S_RMW) begin
			idx_q <= idx_n;
			cnt_q <= cnt_n;
			sum_q <= sum_n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			mean_q  <= div_quo;
			count_q <= cnt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign mean      = mean_q;
	assign count     = count_q;

	a_cnt_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= win_eff)
		else $error("valid count above window");

	a_idx_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(idx_q) < win_eff)
		else $error("write index outside window");

	a_out_from_fsm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("output beat without a finished division");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done outside divide state");

endmodule

// ===== tb/sv/moving_average_checker.sv =====
module moving_average_checker (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic [maf_pkg::CFG_W-1:0]                  window_size,
	input  logic                                       in_valid,
	input  logic                                       in_ready,
	input  logic signed [maf_pkg::SAMPLE_BITS_DEF-1:0] sample,
	input  logic                                       out_valid,
	input  logic                                       out_ready,
	input  logic signed [maf_pkg::SAMPLE_BITS_DEF-1:0] mean,
	input  logic [maf_pkg::CFG_W-1:0]                  count,
	output int                                         mismatches,
	output int                                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import maf_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_BITS_DEF-1:0] avg;
		logic [CFG_W-1:0]                  fill;
	} average_t;

	average_t mean_queue[$];

	logic signed [SAMPLE_BITS_DEF-1:0] window_store [WINDOW_MAX_DEF];
	logic [CFG_W-1:0] win_setting = WINDOW_RESET;
	int     wr_pos = 0;
	int     fill = 0;
	longint running_sum = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic average_t advance_average(input logic signed [SAMPLE_BITS_DEF-1:0] s);
		int       span;
		longint   quotient;
		average_t r;
		if (win_setting == 0) begin
			span = 1;
		end else if (win_setting > WINDOW_MAX_DEF) begin
			span = WINDOW_MAX_DEF;
		end else begin
			span = int'(win_setting);
		end
		if (wr_pos >= span) wr_pos = 0;
		if (fill > span) fill = span;
		if (fill == span) running_sum -= window_store[wr_pos];
		window_store[wr_pos] = s;
		running_sum += s;
		wr_pos++;
		if (wr_pos >= span) wr_pos = 0;
		if (fill < span) fill++;
		quotient = running_sum / longint'(fill);
		r.avg  = quotient[SAMPLE_BITS_DEF-1:0];
		r.fill = fill[CFG_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		average_t want;
		if (!arst_n) begin
			mean_queue.delete();
			win_setting = WINDOW_RESET;
			wr_pos      = 0;
			fill        = 0;
			running_sum = 0;
			pending    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (mean_queue.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing expected, mean %0d count %0d",
						mean, count));
				end else begin
					want = mean_queue.pop_front();
					if (mean !== want.avg)
						report_mismatch($sformatf("mean got %0d expected %0d", mean, want.avg));
					if (count !== want.fill)
						report_mismatch($sformatf("count got %0d expected %0d", count, want.fill));
				end
			end
			if (cfg_we) begin
				win_setting = window_size;
				wr_pos      = 0;
				fill        = 0;
				running_sum = 0;
			end
			if (in_valid && in_ready) mean_queue.push_back(advance_average(sample));
			pending <= mean_queue.size();
		end
	end

endmodule

// ===== tb/sv/tb_moving_average_filter_top.sv =====
module tb_moving_average_filter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW          = maf_pkg::SAMPLE_BITS_DEF;
	localparam int CW          = maf_pkg::CFG_W;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_EXTREME} fill_mode_t;

	localparam logic signed [SW-1:0] DIRECTED [14] = '{
		16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF, 16'sh7FFF,
		16'sh8000, 16'sh5555, 16'shAAAA, 16'shFFFE, 16'sh0002, 16'shFFFD, 16'sh8000
	};

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CW-1:0]        window_size = maf_pkg::WINDOW_RESET;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic signed [SW-1:0] sample      = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic signed [SW-1:0] mean;
	logic [CW-1:0]        count;
	logic                 steady      = 1'b0;
	int                   mismatches;
	int                   pending;
	int                   cycles      = 0;

	moving_average_filter_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.window_size(window_size),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mean       (mean),
		.count      (count)
	);

	moving_average_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.window_size(window_size),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mean       (mean),
		.count      (count),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 8);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic signed [SW-1:0] pick_sample(input fill_mode_t mode);
		case (mode)
			FILL_MAX: return 16'sh7FFF;
			FILL_MIN: return 16'sh8000;
			FILL_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'shFFFF;
					default: return SW'($urandom);
				endcase
			end
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic push_sample(input logic signed [SW-1:0] v);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 8) gap = $urandom_range(1, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// pending is registered in the checker, so let the last beat reach it first
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CW-1:0] w, input int n, input fill_mode_t mode);
		drain();
		cfg_we      <= 1'b1;
		window_size <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (n) push_sample(pick_sample(mode));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of 16, extremes and truncation of negative sums
		foreach (DIRECTED[i]) push_sample(DIRECTED[i]);

		run_phase(7'd1, 20, FILL_EXTREME);
		run_phase(7'd0, 15, FILL_RANDOM);
		steady <= 1'b1;
		run_phase(7'd64, 80, FILL_MIN);
		steady <= 1'b0;
		run_phase(7'd127, 80, FILL_MAX);
		run_phase(7'd65, 70, FILL_EXTREME);
		run_phase(7'd2, 25, FILL_RANDOM);
		run_phase(7'd63, 70, FILL_RANDOM);
		repeat (2) run_phase(CW'($urandom_range(1, 127)), 30, FILL_RANDOM);
		run_phase(7'd16, 20, FILL_EXTREME);

		drain();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
